/* hdl/ftsd_pkg.sv */
`timescale 1ns / 1ps
package ftsd_pkg;

  localparam int MAX_CALIB_DEF = 4096;

  localparam int IN_DATA_W   = 48;
  localparam int IN_USER_W   = 8;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_USER_W  = 4;
  localparam int AXIS_W      = 18;
  localparam int OFFSET_W    = 17;
  localparam int KIND_W      = 3;
  localparam int ID_W        = 8;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int NUM_AXES    = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ID       = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_SAMPLES = 1'd1;

  localparam logic [CFG_DATA_W-1:0] CALIB_SAMPLES_RST = 13'd1024;

  localparam logic [KIND_W-1:0] KIND_FORCE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MOMENT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LIN_ACC = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ANG_ACC = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

  localparam logic signed [AXIS_W-1:0] FORCE_BIAS  = 18'sd30000;
  localparam logic signed [AXIS_W-1:0] MOMENT_BIAS = 18'sd25000;
  localparam logic signed [AXIS_W-1:0] ACC_BIAS    = 18'sd65535;

  typedef struct packed {
    logic              take;
    logic [KIND_W-1:0] kind;
    logic              corr;
    logic              accum;
    logic              div_start;
  } lane_ctl_t;

endpackage

/* hdl/ftsd_div.sv */
`timescale 1ns / 1ps
module ftsd_div #(
  parameter int DW = 30,
  parameter int VW = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [VW-1:0]        divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);

  localparam int STEP_W = $clog2(DW + 1);

  logic              busy;
  logic              neg;
  logic [STEP_W-1:0] step;
  logic [VW-1:0]     rem;
  logic [DW-1:0]     quo;
  logic [VW-1:0]     dvsr;
  logic [VW:0]       trial;
  logic              fits;

  assign trial = {rem, quo[DW-1]};
  assign fits  = trial >= {1'b0, dvsr};
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[DW-1];
      quo  <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= fits ? VW'(trial - {1'b0, dvsr}) : trial[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

/* hdl/ftsd_lane.sv */
`timescale 1ns / 1ps
module ftsd_lane #(
  parameter int MAX_CALIB = ftsd_pkg::MAX_CALIB_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ftsd_pkg::lane_ctl_t                   ctl,
  input  logic [7:0]                            word_hi,
  input  logic [7:0]                            word_lo,
  input  logic [$clog2(MAX_CALIB+1)-1:0]        count,
  output logic signed [ftsd_pkg::AXIS_W-1:0]    axis,
  output logic                                  div_done
);
  import ftsd_pkg::*;

  localparam int CW = $clog2(MAX_CALIB + 1);
  localparam int SW = CW + OFFSET_W;

  logic signed [15:0]         raw;
  logic signed [AXIS_W-1:0]   raw_ext;
  logic signed [AXIS_W-1:0]   force_val;
  logic signed [AXIS_W-1:0]   moment_val;
  logic signed [AXIS_W-1:0]   acc_val;
  logic signed [AXIS_W-1:0]   force_corr;
  logic signed [AXIS_W-1:0]   moment_corr;
  logic signed [AXIS_W-1:0]   latched_force;
  logic signed [AXIS_W-1:0]   latched_moment;
  logic signed [SW-1:0]       force_sum;
  logic signed [SW-1:0]       moment_sum;
  logic signed [OFFSET_W-1:0] force_offset;
  logic signed [OFFSET_W-1:0] moment_offset;
  logic signed [SW-1:0]       force_quo;
  logic signed [SW-1:0]       moment_quo;
  logic                       force_done;
  logic                       moment_done;

  assign raw         = $signed({word_hi, word_lo});
  assign raw_ext     = {{(AXIS_W-16){raw[15]}}, raw};
  assign force_corr  = ctl.corr ? {force_offset[OFFSET_W-1], force_offset} : '0;
  assign moment_corr = ctl.corr ? {moment_offset[OFFSET_W-1], moment_offset} : '0;
  assign force_val   = raw_ext - FORCE_BIAS - force_corr;
  assign moment_val  = raw_ext - MOMENT_BIAS - moment_corr;
  assign acc_val     = {raw[15], raw, 1'b0} - ACC_BIAS;
  assign div_done    = force_done & moment_done;

  always_comb begin
    case (ctl.kind)
      KIND_FORCE:   axis = force_val;
      KIND_MOMENT:  axis = moment_val;
      KIND_LIN_ACC: axis = acc_val;
      default:      axis = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_force  <= '0;
      latched_moment <= '0;
      force_sum      <= '0;
      moment_sum     <= '0;
      force_offset   <= '0;
      moment_offset  <= '0;
    end else begin
      if (ctl.take && ctl.kind == KIND_FORCE) begin
        latched_force <= force_val;
      end
      if (ctl.take && ctl.kind == KIND_MOMENT) begin
        latched_moment <= moment_val;
      end
      // latched values already hold this item's update
      if (ctl.accum) begin
        force_sum  <= force_sum + {{(SW-AXIS_W){latched_force[AXIS_W-1]}}, latched_force};
        moment_sum <= moment_sum + {{(SW-AXIS_W){latched_moment[AXIS_W-1]}}, latched_moment};
      end
      if (div_done) begin
        force_offset  <= force_quo[OFFSET_W-1:0];
        moment_offset <= moment_quo[OFFSET_W-1:0];
      end
    end
  end

  ftsd_div #(
    .DW (SW),
    .VW (CW)
  ) u_force_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (force_sum),
    .divisor  (count),
    .done     (force_done),
    .quotient (force_quo)
  );

  ftsd_div #(
    .DW (SW),
    .VW (CW)
  ) u_moment_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (moment_sum),
    .divisor  (count),
    .done     (moment_done),
    .quotient (moment_quo)
  );

endmodule

/* hdl/ft_sensor_frame_decoder_with_tare.sv */
`timescale 1ns / 1ps
// the output register holds the result valid in the cycle after input accept
// throughput: one item per cycle while the output is free; the frame that forms the offsets blocks input
// through the load state and the division (one quotient bit per cycle) until both dividers in every lane are done
// three axis lanes scale in parallel, each with a force and a moment divider
// rst (synchronous) clears latched values, sums, offsets, count and calibrated flag
module ft_sensor_frame_decoder_with_tare #(
  parameter int MAX_CALIB_SAMPLES = ftsd_pkg::MAX_CALIB_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ftsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ftsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // x_high, x_low, y_high, y_low, z_high, z_low
  input  logic [ftsd_pkg::IN_DATA_W-1:0]      s_tdata,
  // frame tag byte
  input  logic [ftsd_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // axis_x, axis_y, axis_z, zero pad
  output logic [ftsd_pkg::OUT_DATA_W-1:0]     m_tdata,
  // frame_kind, calibrated
  output logic [ftsd_pkg::OUT_USER_W-1:0]     m_tuser
);
  import ftsd_pkg::*;

  localparam int CW = $clog2(MAX_CALIB_SAMPLES + 1);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]              state;
  logic [ID_W-1:0]         base_id;
  logic [CFG_DATA_W-1:0]   calib_samples;
  logic [CW-1:0]           tare_count;
  logic [CW-1:0]           eff_samples;
  logic                    offsets_ready;
  logic                    accum;
  logic                    accept;
  logic                    out_free;
  logic [KIND_W-1:0]       kind;
  lane_ctl_t               ctl;
  logic signed [AXIS_W-1:0] axis [NUM_AXES];
  logic [NUM_AXES-1:0]     lane_done;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_RUN) && out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (calib_samples == '0) begin
      eff_samples = CW'(1);
    end else if (32'(calib_samples) > 32'(MAX_CALIB_SAMPLES)) begin
      eff_samples = CW'(MAX_CALIB_SAMPLES);
    end else begin
      eff_samples = CW'(calib_samples);
    end
  end

  // ids above the last byte value never match
  always_comb begin
    if ({1'b0, s_tuser} == {1'b0, base_id}) begin
      kind = KIND_FORCE;
    end else if ({1'b0, s_tuser} == {1'b0, base_id} + 9'd1) begin
      kind = KIND_MOMENT;
    end else if ({1'b0, s_tuser} == {1'b0, base_id} + 9'd2) begin
      kind = KIND_LIN_ACC;
    end else if ({1'b0, s_tuser} == {1'b0, base_id} + 9'd3) begin
      kind = KIND_ANG_ACC;
    end else begin
      kind = KIND_NONE;
    end
  end

  assign ctl.take      = accept;
  assign ctl.kind      = kind;
  assign ctl.corr      = offsets_ready;
  assign ctl.accum     = accum;
  assign ctl.div_start = (state == ST_LOAD);

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    ftsd_lane #(
      .MAX_CALIB (MAX_CALIB_SAMPLES)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .word_hi  (s_tdata[16*i +: 8]),
      .word_lo  (s_tdata[16*i+8 +: 8]),
      .count    (tare_count),
      .axis     (axis[i]),
      .div_done (lane_done[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      base_id       <= '0;
      calib_samples <= CALIB_SAMPLES_RST;
      tare_count    <= '0;
      offsets_ready <= 1'b0;
      accum         <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_ID:       base_id <= cfg_data[ID_W-1:0];
          CFG_CALIB_SAMPLES: calib_samples <= cfg_data;
          default: ;
        endcase
      end
      accum <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end
      case (state)
        ST_RUN: begin
          if (accept && !offsets_ready) begin
            if (tare_count < eff_samples) begin
              tare_count <= tare_count + 1'b1;
              accum      <= 1'b1;
            end else begin
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (&lane_done) begin
            offsets_ready <= 1'b1;
            state         <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{(OUT_DATA_W - NUM_AXES*AXIS_W){1'b0}}, axis[2], axis[1], axis[0]};
      m_tuser <= {offsets_ready, kind};
    end
  end

endmodule

/* hdl/ftsd_checker.sv */
`timescale 1ns / 1ps
module ftsd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ftsd_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [ftsd_pkg::OUT_USER_W-1:0]  m_tuser
);
  import ftsd_pkg::*;

  logic seen_cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_cal <= 1'b0;
    end else if (m_tvalid && m_tuser[3]) begin
      seen_cal <= 1'b1;
    end
  end

  // angular and unrecognized frames carry zero axes
  a_zero_axes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == KIND_ANG_ACC || m_tuser[2:0] == KIND_NONE)
    |-> m_tdata[NUM_AXES*AXIS_W-1:0] == '0)
    else $error("nonzero axes on a frame without data");

  // calibrated flag never drops once shown
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_cal |-> m_tuser[3])
    else $error("calibrated flag dropped");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:NUM_AXES*AXIS_W] == '0)
    else $error("pad bits set");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind ft_sensor_frame_decoder_with_tare ftsd_checker u_ftsd_checker (.*);

/* sim/ft_sensor_frame_decoder_with_tare_tb.sv */
`timescale 1ns / 1ps
module ft_sensor_frame_decoder_with_tare_tb;
  import ftsd_pkg::*;

  localparam int FORCE_ZERO_RAW  = 30000;
  localparam int MOMENT_ZERO_RAW = 25000;
  localparam int ACC_ZERO_RAW    = 65535;
  localparam int TARE_MAX        = 4096;
  localparam int DIV_SETTLE      = 40;

  typedef struct packed {
    logic [KIND_W-1:0]                 kind;
    logic [NUM_AXES-1:0][AXIS_W-1:0]   axis;
    logic                              calibrated;
  } decoded_frame_t;

  class frame_scoreboard;
    logic [ID_W-1:0]       base_id;
    logic [CFG_DATA_W-1:0] tare_len;
    int                    latch_force[3];
    int                    latch_moment[3];
    longint                sum_force[3];
    longint                sum_moment[3];
    int                    off_force[3];
    int                    off_moment[3];
    int unsigned           summed;
    bit                    tared;
    decoded_frame_t        decoded_q[$];
    int                    errors;
    int                    results;
    int                    kind_seen[5];
    int                    tare_divisor;

    function new();
      base_id = '0;
      tare_len = CALIB_SAMPLES_RST;
      for (int a = 0; a < 3; a++) begin
        latch_force[a] = 0;
        latch_moment[a] = 0;
        sum_force[a] = 0;
        sum_moment[a] = 0;
        off_force[a] = 0;
        off_moment[a] = 0;
      end
      summed = 0;
      tared = 1'b0;
      errors = 0;
      results = 0;
      tare_divisor = 0;
      for (int k = 0; k < 5; k++) kind_seen[k] = 0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
      if (idx == CFG_BASE_ID) base_id = value[ID_W-1:0];
      else if (idx == CFG_CALIB_SAMPLES) tare_len = value[CFG_DATA_W-1:0];
    endfunction

    function void note_frame(logic [ID_W-1:0] fid, logic [IN_DATA_W-1:0] payload);
      int             raw[3];
      int             res[3];
      logic [KIND_W-1:0] kind;
      bit             was_tared;
      int unsigned    eff;
      decoded_frame_t d;
      was_tared = tared;
      for (int a = 0; a < 3; a++) begin
        raw[a] = $signed({payload[16*a +: 8], payload[16*a+8 +: 8]});
        res[a] = 0;
      end
      if (int'(fid) == int'(base_id)) kind = KIND_FORCE;
      else if (int'(fid) == int'(base_id) + 1) kind = KIND_MOMENT;
      else if (int'(fid) == int'(base_id) + 2) kind = KIND_LIN_ACC;
      else if (int'(fid) == int'(base_id) + 3) kind = KIND_ANG_ACC;
      else kind = KIND_NONE;
      kind_seen[kind]++;
      for (int a = 0; a < 3; a++) begin
        case (kind)
          KIND_FORCE: begin
            latch_force[a] = raw[a] - FORCE_ZERO_RAW - (was_tared ? off_force[a] : 0);
            res[a] = latch_force[a];
          end
          KIND_MOMENT: begin
            latch_moment[a] = raw[a] - MOMENT_ZERO_RAW - (was_tared ? off_moment[a] : 0);
            res[a] = latch_moment[a];
          end
          KIND_LIN_ACC: res[a] = 2 * raw[a] - ACC_ZERO_RAW;
          default: res[a] = 0;
        endcase
      end
      if (!tared) begin
        eff = tare_len;
        if (eff == 0) eff = 1;
        if (eff > TARE_MAX) eff = TARE_MAX;
        if (summed < eff) begin
          for (int a = 0; a < 3; a++) begin
            sum_force[a] += latch_force[a];
            sum_moment[a] += latch_moment[a];
          end
          summed++;
        end else if (summed != 0) begin
          for (int a = 0; a < 3; a++) begin
            off_force[a] = int'(sum_force[a] / longint'(summed));
            off_moment[a] = int'(sum_moment[a] / longint'(summed));
          end
          tared = 1'b1;
          tare_divisor = summed;
        end
      end
      d.kind = kind;
      for (int a = 0; a < 3; a++) d.axis[a] = res[a][AXIS_W-1:0];
      d.calibrated = was_tared;
      decoded_q.push_back(d);
    endfunction

    task report(string what, int expected, int got);
      errors++;
      $display("mismatch at result %0d: %s expected %0d got %0d",
               results, what, expected, got);
    endtask

    task check_decoded(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      decoded_frame_t e;
      string          axis_name[3];
      axis_name = '{"axis_x", "axis_y", "axis_z"};
      results++;
      if (decoded_q.size() == 0) begin
        report("result with no frame pending, kind", -1, int'(user[KIND_W-1:0]));
        return;
      end
      e = decoded_q.pop_front();
      if (user[KIND_W-1:0] !== e.kind)
        report("frame_kind", int'(e.kind), int'(user[KIND_W-1:0]));
      for (int a = 0; a < 3; a++)
        if (data[AXIS_W*a +: AXIS_W] !== e.axis[a])
          report(axis_name[a], int'($signed(e.axis[a])),
                 int'($signed(data[AXIS_W*a +: AXIS_W])));
      if (user[KIND_W] !== e.calibrated)
        report("calibrated", int'(e.calibrated), int'(user[KIND_W]));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic [IN_USER_W-1:0]   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;

  frame_scoreboard sb = new();
  bit              send_burst;
  bit              recv_burst;

  ft_sensor_frame_decoder_with_tare i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [IN_DATA_W-1:0] pack_words(logic [15:0] wx, logic [15:0] wy,
                                                      logic [15:0] wz);
    return {wz[7:0], wz[15:8], wy[7:0], wy[15:8], wx[7:0], wx[15:8]};
  endfunction

  function automatic logic [15:0] rand_word();
    logic [15:0] corner[6];
    corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7530, 16'h61A8};
    if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_payload();
    return pack_words(rand_word(), rand_word(), rand_word());
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    sb.set_reg(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input logic [ID_W-1:0] fid, input logic [IN_DATA_W-1:0] payload);
    int gap;
    if ($urandom_range(0, 47) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fid;
    s_tdata <= payload;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_frame(fid, payload);
  endtask

  task automatic wait_drained(input int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    logic [ID_W-1:0] fid;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) fid = ID_W'(sb.base_id + $urandom_range(0, 3));
      else fid = ID_W'($urandom_range(0, 255));
      send_frame(fid, rand_payload());
      if ($urandom_range(0, 59) == 0) wait_drained(0);
    end
  endtask

  initial begin
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      int gap;
      if ($urandom_range(0, 47) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_decoded(m_tdata, m_tuser);
    end
  end

  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // oversized count keeps tare running through the early phases
    write_reg(CFG_CALIB_SAMPLES, 8191);
    write_reg(CFG_BASE_ID, 0);
    send_frame(8'd0, pack_words(16'h8000, 16'h7FFF, 16'h0000));
    send_frame(8'd0, pack_words(16'h7FFF, 16'h8000, 16'hFFFF));
    send_frame(8'd1, pack_words(16'h8000, 16'h7FFF, 16'h0000));
    send_frame(8'd1, pack_words(16'h7FFF, 16'h8000, 16'hFFFF));
    send_frame(8'd2, pack_words(16'h8000, 16'h7FFF, 16'h0000));
    send_frame(8'd2, pack_words(16'h7FFF, 16'h8000, 16'hFFFF));
    send_frame(8'd3, pack_words(16'hFFFF, 16'h7FFF, 16'h8000));
    send_frame(8'd4, pack_words(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_frame(8'd255, pack_words(16'h7FFF, 16'h0000, 16'h8000));
    send_frame(8'd128, rand_payload());
    send_frame(8'd0, pack_words(16'h7530, 16'h7530, 16'h7530));

    // high base ids, no wrap of the upper kinds
    wait_drained(DIV_SETTLE);
    write_reg(CFG_BASE_ID, 252);
    for (int i = 0; i < 5; i++) send_frame(ID_W'(252 + i), rand_payload());
    wait_drained(DIV_SETTLE);
    write_reg(CFG_BASE_ID, 255);
    send_frame(8'd255, rand_payload());
    send_frame(8'd0, rand_payload());
    send_frame(8'd254, rand_payload());

    wait_drained(DIV_SETTLE);
    write_reg(CFG_BASE_ID, 17);
    run_random(300);

    // count dropped below the samples already summed, next item forms offsets
    wait_drained(DIV_SETTLE);
    write_reg(CFG_CALIB_SAMPLES, 0);
    run_random(400);

    wait_drained(DIV_SETTLE);
    write_reg(CFG_BASE_ID, 252);
    write_reg(CFG_CALIB_SAMPLES, 4096);
    run_random(350);

    wait_drained(DIV_SETTLE);
    write_reg(CFG_BASE_ID, $urandom_range(0, 255));
    write_reg(CFG_CALIB_SAMPLES, 1);
    run_random(350);

    wait_drained(DIV_SETTLE);
    $display("checked %0d results: %0d force, %0d moment, %0d lin acc, %0d ang acc, %0d other",
             sb.results, sb.kind_seen[KIND_FORCE], sb.kind_seen[KIND_MOMENT],
             sb.kind_seen[KIND_LIN_ACC], sb.kind_seen[KIND_ANG_ACC],
             sb.kind_seen[KIND_NONE]);
    $display("tare offsets formed from %0d summed frames, %0d mismatches",
             sb.tare_divisor, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ftsd_pkg.sv
hdl/ftsd_div.sv
hdl/ftsd_lane.sv
hdl/ft_sensor_frame_decoder_with_tare.sv
hdl/ftsd_checker.sv
sim/ft_sensor_frame_decoder_with_tare_tb.sv
